// File: src/ucfp_pkg.sv
// Shared types and constants for the UART command frame parser.
// No dependencies.
package ucfp_pkg;

  // Result event codes
  typedef enum logic [2:0] {
    EV_JAM      = 3'd0,
    EV_CHAR     = 3'd1,
    EV_LITERAL  = 3'd2,
    EV_POINTER  = 3'd3,
    EV_DATAPATH = 3'd4,
    EV_TRIGGER  = 3'd5,
    EV_BADTYPE  = 3'd6,
    EV_EMPTY    = 3'd7
  } event_t;

  // Frame type bytes
  localparam logic [7:0] TYPE_JAM      = 8'd0;
  localparam logic [7:0] TYPE_CHAR     = 8'd1;
  localparam logic [7:0] TYPE_LITERAL  = 8'd2;
  localparam logic [7:0] TYPE_POINTER  = 8'd3;
  localparam logic [7:0] TYPE_DATAPATH = 8'd4;
  localparam logic [7:0] TYPE_TRIGGER  = 8'd5;

  // Framing constants
  localparam logic [7:0] PTR_LEN_EXPECTED  = 8'd10;
  localparam logic [7:0] CHAR_LEN_OVERHEAD = 8'd2;
  localparam logic [2:0] PTR_LAST_INDEX    = 3'd7;

endpackage

// File: src/uart_command_frame_parser.sv
// The result is registered: it is presented in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the single result register frees in the cycle it is taken,
// so rx_ready only drops while a result waits and res_ready is low.
// Reset (rst, synchronous, active high): parser returns to expecting a type byte,
// counters and accumulators clear, and no result is held.
// Depends on ucfp_pkg.
module uart_command_frame_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                rx_valid,
  output logic                rx_ready,
  input  logic [7:0]          rx_byte,
  output logic                res_valid,
  input  logic                res_ready,
  output ucfp_pkg::event_t    event_res,
  output logic [7:0]          char_data,
  output logic [31:0]         address,
  output logic [31:0]         pointer_length,
  output logic                length_error,
  output logic                last
);
  import ucfp_pkg::*;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_CHAR_LEN,
    PH_CHAR,
    PH_PTR_LEN,
    PH_PTR_WORD
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  remaining, remaining_next;
  logic [2:0]  word_byte_index, word_byte_index_next;
  logic [31:0] address_acc, address_acc_next;
  logic [31:0] length_acc, length_acc_next;
  logic        length_err_flag, length_err_flag_next;

  logic        rx_fire;
  logic        emit;
  event_t      ev;
  logic [7:0]  ch;
  logic [31:0] placed;
  logic        is_last;

  // Accept a byte whenever the result register is empty or being drained
  assign rx_ready = !res_valid || res_ready;
  assign rx_fire  = rx_valid && rx_ready;

  // Place the incoming byte at its lane within the current word
  always_comb begin
    case (word_byte_index[1:0])
      2'd0:    placed = {24'd0, rx_byte};
      2'd1:    placed = {16'd0, rx_byte, 8'd0};
      2'd2:    placed = {8'd0, rx_byte, 16'd0};
      default: placed = {rx_byte, 24'd0};
    endcase
  end

  // Next state and result for one accepted byte
  always_comb begin
    phase_next           = phase;
    remaining_next       = remaining;
    word_byte_index_next = word_byte_index;
    address_acc_next     = address_acc;
    length_acc_next      = length_acc;
    length_err_flag_next = length_err_flag;
    emit    = 1'b0;
    ev      = EV_JAM;
    ch      = 8'd0;
    is_last = 1'b1;

    case (phase)
      PH_CHAR_LEN: begin
        if (rx_byte <= CHAR_LEN_OVERHEAD) begin
          phase_next = PH_TYPE;
          emit       = 1'b1;
          ev         = EV_EMPTY;
        end else begin
          remaining_next = rx_byte - CHAR_LEN_OVERHEAD;
          phase_next     = PH_CHAR;
        end
      end
      PH_CHAR: begin
        remaining_next = remaining - 8'd1;
        is_last        = (remaining_next == 8'd0);
        if (is_last) begin
          phase_next = PH_TYPE;
        end
        emit = 1'b1;
        ev   = EV_CHAR;
        ch   = rx_byte;
      end
      PH_PTR_LEN: begin
        length_err_flag_next = (rx_byte != PTR_LEN_EXPECTED);
        word_byte_index_next = 3'd0;
        address_acc_next     = 32'd0;
        length_acc_next      = 32'd0;
        phase_next           = PH_PTR_WORD;
      end
      PH_PTR_WORD: begin
        if (!word_byte_index[2]) begin
          address_acc_next = address_acc | placed;
        end else begin
          length_acc_next = length_acc | placed;
        end
        if (word_byte_index == PTR_LAST_INDEX) begin
          word_byte_index_next = 3'd0;
          phase_next           = PH_TYPE;
          emit                 = 1'b1;
          ev                   = EV_POINTER;
        end else begin
          word_byte_index_next = word_byte_index + 3'd1;
        end
      end
      default: begin
        phase_next = PH_TYPE;
        emit       = 1'b1;
        case (rx_byte)
          TYPE_JAM:      ev = EV_JAM;
          TYPE_CHAR: begin
            emit       = 1'b0;
            phase_next = PH_CHAR_LEN;
          end
          TYPE_LITERAL:  ev = EV_LITERAL;
          TYPE_POINTER: begin
            emit       = 1'b0;
            phase_next = PH_PTR_LEN;
          end
          TYPE_DATAPATH: ev = EV_DATAPATH;
          TYPE_TRIGGER:  ev = EV_TRIGGER;
          default:       ev = EV_BADTYPE;
        endcase
      end
    endcase
  end

  // Hold parser state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_TYPE;
      remaining       <= 8'd0;
      word_byte_index <= 3'd0;
      address_acc     <= 32'd0;
      length_acc      <= 32'd0;
      length_err_flag <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      // Drop the result once taken; a new one may replace it in the same cycle
      if (rx_fire && emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (rx_fire) begin
        phase           <= phase_next;
        remaining       <= remaining_next;
        word_byte_index <= word_byte_index_next;
        address_acc     <= address_acc_next;
        length_acc      <= length_acc_next;
        length_err_flag <= length_err_flag_next;
        if (emit) begin
          event_res      <= ev;
          char_data      <= ch;
          address        <= (ev == EV_POINTER) ? address_acc_next : 32'd0;
          pointer_length <= (ev == EV_POINTER) ? length_acc_next : 32'd0;
          length_error   <= (ev == EV_POINTER) ? length_err_flag : 1'b0;
          last           <= is_last;
        end
      end
    end
  end

`ifndef SYNTHESIS
  // Word byte counter only moves inside a pointer frame
  assert property (@(posedge clk) disable iff (rst)
    phase != PH_PTR_WORD |-> word_byte_index == 3'd0)
    else $error("word byte index nonzero outside pointer words");

  // A message in progress always has characters left
  assert property (@(posedge clk) disable iff (rst)
    phase == PH_CHAR |-> remaining != 8'd0)
    else $error("character phase with no characters remaining");

  // The final character of a message returns the parser to the type byte
  assert property (@(posedge clk) disable iff (rst)
    rx_fire && phase == PH_CHAR && remaining == 8'd1 |=> phase == PH_TYPE)
    else $error("parser did not return to type byte after last character");

  // Length error only ever accompanies a pointer result
  assert property (@(posedge clk) disable iff (rst)
    res_valid && length_error |-> event_res == EV_POINTER)
    else $error("length error on a non-pointer result");

  // Every result that is not a character is marked last
  assert property (@(posedge clk) disable iff (rst)
    res_valid && event_res != EV_CHAR |-> last)
    else $error("non-character result not marked last");
`endif

endmodule

// File: tb/uart_command_frame_parser_tb.sv
// Self-checking testbench for uart_command_frame_parser: directed and random
// frame traffic with a cycle-free byte-level predictor of the deframer.
// Depends on ucfp_pkg and the uart_command_frame_parser RTL.
`timescale 1ns / 100ps

module uart_command_frame_parser_tb;
  import ucfp_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTS  = 60;

  typedef enum {
    AWAIT_TYPE,
    AWAIT_MSG_LEN,
    IN_MESSAGE,
    AWAIT_PTR_LEN,
    IN_PTR_WORDS
  } deframe_phase_t;

  typedef struct {
    event_t      ev;
    logic [7:0]  ch;
    logic [31:0] addr;
    logic [31:0] plen;
    logic        err;
    logic        last;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        rx_valid;
  logic        rx_ready;
  logic [7:0]  rx_byte;
  logic        res_valid;
  logic        res_ready;
  event_t      event_res;
  logic [7:0]  char_data;
  logic [31:0] address;
  logic [31:0] pointer_length;
  logic        length_error;
  logic        last;

  // Predictor state
  deframe_phase_t phase_q;
  logic [7:0]     msg_left;
  logic [2:0]     word_idx;
  logic [31:0]    addr_acc;
  logic [31:0]    plen_acc;
  logic           ptr_len_bad;

  frame_result_t expected_events[$];
  int            mismatch_count = 0;
  int            bytes_sent = 0;
  bit            idle_en = 1'b1;
  bit            hold_req = 1'b0;

  uart_command_frame_parser dut (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (rx_valid),
    .rx_ready       (rx_ready),
    .rx_byte        (rx_byte),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .event_res      (event_res),
    .char_data      (char_data),
    .address        (address),
    .pointer_length (pointer_length),
    .length_error   (length_error),
    .last           (last)
  );

  always #5 clk = ~clk;

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Queue one expected result
  task automatic push_event(input event_t ev, input logic [7:0] ch, input logic [31:0] addr,
                            input logic [31:0] plen, input logic err, input logic lst);
    frame_result_t r;
    r.ev   = ev;
    r.ch   = ch;
    r.addr = addr;
    r.plen = plen;
    r.err  = err;
    r.last = lst;
    expected_events.insert(expected_events.size(), r);
  endtask

  // Advance the deframer by one accepted byte
  task automatic deframe_byte(input logic [7:0] b);
    case (phase_q)
      AWAIT_MSG_LEN: begin
        if (b <= CHAR_LEN_OVERHEAD) begin
          phase_q = AWAIT_TYPE;
          push_event(EV_EMPTY, '0, '0, '0, 1'b0, 1'b1);
        end else begin
          msg_left = b - CHAR_LEN_OVERHEAD;
          phase_q  = IN_MESSAGE;
        end
      end
      IN_MESSAGE: begin
        msg_left = msg_left - 8'd1;
        if (msg_left == 8'd0) phase_q = AWAIT_TYPE;
        push_event(EV_CHAR, b, '0, '0, 1'b0, msg_left == 8'd0);
      end
      AWAIT_PTR_LEN: begin
        ptr_len_bad = (b != PTR_LEN_EXPECTED);
        word_idx    = '0;
        addr_acc    = '0;
        plen_acc    = '0;
        phase_q     = IN_PTR_WORDS;
      end
      IN_PTR_WORDS: begin
        if (!word_idx[2]) addr_acc[word_idx[1:0]*8 +: 8] = b;
        else              plen_acc[word_idx[1:0]*8 +: 8] = b;
        if (word_idx == PTR_LAST_INDEX) begin
          word_idx = '0;
          phase_q  = AWAIT_TYPE;
          push_event(EV_POINTER, '0, addr_acc, plen_acc, ptr_len_bad, 1'b1);
        end else begin
          word_idx = word_idx + 3'd1;
        end
      end
      default: begin
        phase_q = AWAIT_TYPE;
        case (b)
          TYPE_JAM:      push_event(EV_JAM, '0, '0, '0, 1'b0, 1'b1);
          TYPE_CHAR:     phase_q = AWAIT_MSG_LEN;
          TYPE_LITERAL:  push_event(EV_LITERAL, '0, '0, '0, 1'b0, 1'b1);
          TYPE_POINTER:  phase_q = AWAIT_PTR_LEN;
          TYPE_DATAPATH: push_event(EV_DATAPATH, '0, '0, '0, 1'b0, 1'b1);
          TYPE_TRIGGER:  push_event(EV_TRIGGER, '0, '0, '0, 1'b0, 1'b1);
          default:       push_event(EV_BADTYPE, '0, '0, '0, 1'b0, 1'b1);
        endcase
      end
    endcase
  endtask

  // Offer one byte, optionally after a gap, and hold it until the transaction completes
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 6) == 0) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!rx_ready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_checker
    frame_result_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result, event %0d", event_res));
      end else begin
        want = expected_events.pop_front();
        if (event_res !== want.ev)
          report_mismatch($sformatf("event %0d, want %0d", event_res, want.ev));
        if (char_data !== want.ch)
          report_mismatch($sformatf("char_data %02h, want %02h", char_data, want.ch));
        if (address !== want.addr)
          report_mismatch($sformatf("address %08h, want %08h", address, want.addr));
        if (pointer_length !== want.plen)
          report_mismatch($sformatf("pointer_length %08h, want %08h",
                                    pointer_length, want.plen));
        if (length_error !== want.err)
          report_mismatch($sformatf("length_error %0b, want %0b", length_error, want.err));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", last, want.last));
      end
    end
  end

  // One-byte frames and bad type bytes
  task automatic test_single_byte_frames();
    send_byte(TYPE_JAM);
    send_byte(TYPE_LITERAL);
    send_byte(TYPE_DATAPATH);
    send_byte(TYPE_TRIGGER);
    send_byte(8'd6);
    send_byte(8'hFF);
  endtask

  // Empty messages and a two-character message at the byte extremes
  task automatic test_message_frames();
    send_byte(TYPE_CHAR);
    send_byte(CHAR_LEN_OVERHEAD);
    send_byte(TYPE_CHAR);
    send_byte(8'd0);
    send_byte(TYPE_CHAR);
    send_byte(8'd4);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // Pointer frame with a wrong length byte
  task automatic test_pointer_frames();
    send_byte(TYPE_POINTER);
    send_byte(8'd9);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'hFF);
  endtask

  // One random frame; mostly well formed, some noise and truncated frames
  task automatic send_random_frame();
    int kind;
    int body;
    int lsel;
    logic [7:0] len;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      send_byte(8'($urandom_range(0, 255)));
    end else if (kind < 15) begin
      send_byte(8'($urandom_range(6, 255)));
    end else if (kind < 45) begin
      case ($urandom_range(0, 3))
        0: send_byte(TYPE_JAM);
        1: send_byte(TYPE_LITERAL);
        2: send_byte(TYPE_DATAPATH);
        default: send_byte(TYPE_TRIGGER);
      endcase
    end else if (kind < 75) begin
      lsel = $urandom_range(0, 99);
      if (lsel < 8)       len = 8'($urandom_range(0, 2));
      else if (lsel < 10) len = 8'($urandom_range(100, 255));
      else                len = 8'($urandom_range(3, 18));
      send_byte(TYPE_CHAR);
      send_byte(len);
      body = (len > CHAR_LEN_OVERHEAD) ? int'(len - CHAR_LEN_OVERHEAD) : 0;
      if ($urandom_range(0, 19) == 0) body = $urandom_range(0, body);
      repeat (body) send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(TYPE_POINTER);
      send_byte(($urandom_range(0, 4) != 0) ? PTR_LEN_EXPECTED : 8'($urandom_range(0, 255)));
      body = 8;
      if ($urandom_range(0, 19) == 0) body = $urandom_range(0, 7);
      repeat (body) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_traffic(input int until_count);
    while (bytes_sent < until_count) send_random_frame();
  endtask

  // Hold results off for a long stretch while bytes keep coming
  task automatic test_result_backpressure();
    hold_req = 1'b1;
    repeat (40) send_byte($urandom_range(0, 5) == 1 ? TYPE_JAM : 8'($urandom_range(0, 5)));
  endtask

  initial begin
    int waited;
    rst      = 1'b1;
    rx_valid = 1'b0;
    rx_byte  = '0;
    phase_q     = AWAIT_TYPE;
    msg_left    = '0;
    word_idx    = '0;
    addr_acc    = '0;
    plen_acc    = '0;
    ptr_len_bad = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_byte_frames();
    test_message_frames();
    test_pointer_frames();
    test_random_traffic(500);
    test_result_backpressure();
    test_random_traffic(850);
    idle_en = 1'b0;
    test_random_traffic(950);

    // Drain outstanding results
    @(negedge clk);
    rx_valid <= 1'b0;
    waited = 0;
    while (expected_events.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (5) @(posedge clk);
    if (expected_events.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_events.size()));

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: uart_command_frame_parser.f
src/ucfp_pkg.sv
src/uart_command_frame_parser.sv
tb/uart_command_frame_parser_tb.sv
